// ----- sv/bfds_pkg.sv -----
// ---------------------------------------------------------------------------
// Box filter downscaler package
// Shared beat types, column accumulator entry, register map and widths.
// ---------------------------------------------------------------------------
package bfds_pkg;

   localparam int MAX_DIM_DEF = 128;   // default largest image side
   localparam int PIX_W       = 8;     // channel width
   localparam int REG_W       = 8;     // size register width
   localparam int SUM_W       = 22;    // column sum width
   localparam int CNT_W       = 15;    // column pixel count width
   localparam int ADDR_W      = 4;     // APB byte address width
   localparam int DATA_W      = 32;    // APB data width
   localparam int LANES       = 5;     // divider lanes: four channels + boundary
   localparam int BND_LANE    = 4;

   localparam logic [REG_W-1:0] SRC_WIDTH_RST  = REG_W'(32);
   localparam logic [REG_W-1:0] SRC_HEIGHT_RST = REG_W'(32);
   localparam logic [REG_W-1:0] DST_WIDTH_RST  = REG_W'(24);
   localparam logic [REG_W-1:0] DST_HEIGHT_RST = REG_W'(24);

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] alpha_in;
      logic             start_of_image;
   } req_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] alpha_out;
      logic             end_of_row;
      logic             end_of_image;
   } rsp_beat_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum_blue;
      logic [SUM_W-1:0] sum_green;
      logic [SUM_W-1:0] sum_red;
      logic [SUM_W-1:0] sum_alpha;
      logic [CNT_W-1:0] count;
   } col_entry_type;

   // register file contents plus a one-cycle pulse after any write
   typedef struct packed {
      logic             restart;
      logic [REG_W-1:0] src_width;
      logic [REG_W-1:0] src_height;
      logic [REG_W-1:0] dst_width;
      logic [REG_W-1:0] dst_height;
   } cfg_regs_type;

endpackage

// ----- sv/bfds_csr.sv -----
// ---------------------------------------------------------------------------
// Box filter downscaler register file
// APB-style slave holding the four size registers; flags a restart on write.
// ---------------------------------------------------------------------------
module bfds_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bfds_pkg::ADDR_W-1:0] paddr,
   input  logic [bfds_pkg::DATA_W-1:0] pwdata,
   output logic [bfds_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output bfds_pkg::cfg_regs_type      cfg
);
   import bfds_pkg::*;

   logic [REG_W-1:0] src_width_ff, src_width_in;
   logic [REG_W-1:0] src_height_ff, src_height_in;
   logic [REG_W-1:0] dst_width_ff, dst_width_in;
   logic [REG_W-1:0] dst_height_ff, dst_height_in;
   logic             restart_ff, restart_in;
   logic             wr;
   reg_idx_type      idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite & pready;
   assign idx    = reg_idx_type'(paddr[3:2]);

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      restart_in    = wr;
      if (wr) begin
         unique case (idx)
            REG_SRC_WIDTH:  src_width_in  = pwdata[REG_W-1:0];
            REG_SRC_HEIGHT: src_height_in = pwdata[REG_W-1:0];
            REG_DST_WIDTH:  dst_width_in  = pwdata[REG_W-1:0];
            REG_DST_HEIGHT: dst_height_in = pwdata[REG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SRC_WIDTH:  prdata = DATA_W'(src_width_ff);
         REG_SRC_HEIGHT: prdata = DATA_W'(src_height_ff);
         REG_DST_WIDTH:  prdata = DATA_W'(dst_width_ff);
         REG_DST_HEIGHT: prdata = DATA_W'(dst_height_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
         dst_width_ff  <= DST_WIDTH_RST;
         dst_height_ff <= DST_HEIGHT_RST;
         restart_ff    <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
         restart_ff    <= restart_in;
      end
   end

   assign cfg.restart    = restart_ff;
   assign cfg.src_width  = src_width_ff;
   assign cfg.src_height = src_height_ff;
   assign cfg.dst_width  = dst_width_ff;
   assign cfg.dst_height = dst_height_ff;

endmodule

// ----- sv/bfds_colmem.sv -----
// ---------------------------------------------------------------------------
// Box filter downscaler column memory
// One entry per destination column: four channel sums and a pixel count.
// ---------------------------------------------------------------------------
module bfds_colmem #(
   parameter int MAX_DIM = bfds_pkg::MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_DIM)-1:0]   wr_addr,
   input  bfds_pkg::col_entry_type      wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_DIM)-1:0]   rd_addr,
   output bfds_pkg::col_entry_type      rd_data
);
   import bfds_pkg::*;

   col_entry_type col_mem [MAX_DIM];
   col_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= col_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bfds_div.sv -----
// ---------------------------------------------------------------------------
// Box filter downscaler divider
// Multi-lane restoring divider, one quotient bit per lane per cycle.
// ---------------------------------------------------------------------------
module bfds_div (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [bfds_pkg::LANES-1:0][bfds_pkg::SUM_W-1:0] dividend,
   input  logic [bfds_pkg::LANES-1:0][bfds_pkg::CNT_W-1:0] divisor,
   output logic                                          busy,
   output logic [bfds_pkg::LANES-1:0][bfds_pkg::SUM_W-1:0] quotient
);
   import bfds_pkg::*;

   localparam int ITER_W = $clog2(SUM_W);

   logic                             busy_ff, busy_in;
   logic [ITER_W-1:0]                count_ff, count_in;
   logic [LANES-1:0][CNT_W-1:0]      rem_ff, rem_in;
   logic [LANES-1:0][SUM_W-1:0]      quo_ff, quo_in;
   logic [LANES-1:0][CNT_W-1:0]      dvs_ff, dvs_in;
   logic [LANES-1:0][CNT_W:0]        shifted;
   logic [LANES-1:0]                 ge;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      for (int l = 0; l < LANES; l++) begin
         shifted[l] = {rem_ff[l], quo_ff[l][SUM_W-1]};
         ge[l]      = shifted[l] >= {1'b0, dvs_ff[l]};
      end
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[l] = ge[l] ? CNT_W'(shifted[l] - {1'b0, dvs_ff[l]})
                              : shifted[l][CNT_W-1:0];
            quo_in[l] = {quo_ff[l][SUM_W-2:0], ge[l]};
         end
         count_in = count_ff + ITER_W'(1);
         if (count_ff == ITER_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/box_filter_image_downscale_top.sv -----
// ---------------------------------------------------------------------------
// Box filter image downscaler
// Area-average shrink of a BGRA raster stream, sequenced over a shared divider.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* takes one source pixel per beat in raster order; start_of_image
//    marks the first pixel and restarts the position counters.
//  - rsp_* gives one averaged destination pixel per finished box, with
//    end_of_row / end_of_image flags. A box finishes on its bottom-right pixel.
//  - Sizes are set over the APB port while idle; any write restarts the
//    counters at the next pixel, as a start mark would.
//  - Each pixel goes from accept to ready again through column memory read,
//    accumulate, then the shared 5-lane divider (channel averages plus the
//    next box edge). A pixel that restarts the counters first works out the
//    first box edges, which go through the same divider.
//  - Results sit in an output register; the next pixel is worked on while one
//    waits, and the block only holds at the end of a pixel that produces a
//    result while the previous one is still untaken.
//  - After reset the sizes are 32x32 -> 24x24 and the first pixel restarts
//    the counters. Column sums need no clearing: each box's first pixel
//    overwrites its entry.
// ---------------------------------------------------------------------------
module box_filter_image_downscale_top #(
   parameter int MAX_DIM = bfds_pkg::MAX_DIM_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bfds_pkg::req_beat_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bfds_pkg::rsp_beat_type      rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bfds_pkg::ADDR_W-1:0] paddr,
   input  logic [bfds_pkg::DATA_W-1:0] pwdata,
   output logic [bfds_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import bfds_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int PROD_W = 2 * DIM_W + 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_INIT = 6'b000010,
      S_READ = 6'b000100,
      S_ACC  = 6'b001000,
      S_DIV  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   cfg_regs_type  cfg;
   logic [DIM_W-1:0] sw, sh, dw, dh;

   state_type     state_ff, state_in;
   req_beat_type  pix_ff, pix_in;
   logic          pending_ff, pending_in;
   logic [IDX_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [IDX_W-1:0] box_col_ff, box_col_in, box_row_ff, box_row_in;
   logic [IDX_W-1:0] col_start_ff, col_start_in, row_start_ff, row_start_in;
   logic [DIM_W-1:0] col_bnd_ff, col_bnd_in, row_bnd_ff, row_bnd_in;
   logic [DIM_W-1:0] col_bnd0_ff, col_bnd0_in, row_bnd0_ff, row_bnd0_in;
   logic          upd_col_ff, upd_col_in, upd_row_ff, upd_row_in;
   logic          emit_ff, emit_in, eor_ff, eor_in, eoi_ff, eoi_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_data_ff, rsp_data_in;

   logic                          div_start, div_busy;
   logic [LANES-1:0][SUM_W-1:0]   div_dvd, div_quo;
   logic [LANES-1:0][CNT_W-1:0]   div_dvs;

   logic          mem_wr, mem_rd;
   col_entry_type mem_wdata, mem_rdata;

   logic             accept, first_px, out_free;
   logic [CNT_W-1:0] n_div;
   logic [DIM_W-1:0] sc1, sr1;
   logic [DIM_W:0]   bc2, br2;
   logic [PROD_W-1:0] col_num, row_num;

   bfds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bfds_colmem #(.MAX_DIM(MAX_DIM)) u_colmem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (box_col_ff),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd),
      .rd_addr (box_col_ff),
      .rd_data (mem_rdata)
   );

   bfds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // effective sizes: zero reads as one, source saturates, destination clamps
   always_comb begin
      if (cfg.src_width == '0)                  sw = DIM_W'(1);
      else if (int'(cfg.src_width) > MAX_DIM)   sw = DIM_W'(MAX_DIM);
      else                                      sw = DIM_W'(cfg.src_width);
      if (cfg.src_height == '0)                 sh = DIM_W'(1);
      else if (int'(cfg.src_height) > MAX_DIM)  sh = DIM_W'(MAX_DIM);
      else                                      sh = DIM_W'(cfg.src_height);
      if (cfg.dst_width == '0)                  dw = DIM_W'(1);
      else if (int'(cfg.dst_width) > int'(sw))  dw = sw;
      else                                      dw = DIM_W'(cfg.dst_width);
      if (cfg.dst_height == '0)                 dh = DIM_W'(1);
      else if (int'(cfg.dst_height) > int'(sh)) dh = sh;
      else                                      dh = DIM_W'(cfg.dst_height);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_rd    = (state_ff == S_READ);
   assign mem_wr    = (state_ff == S_ACC);

   // accumulate into the column entry; a box's first pixel overwrites it
   always_comb begin
      first_px = (src_col_ff == col_start_ff) && (src_row_ff == row_start_ff);
      if (first_px) begin
         mem_wdata.sum_blue  = SUM_W'(pix_ff.blue_in);
         mem_wdata.sum_green = SUM_W'(pix_ff.green_in);
         mem_wdata.sum_red   = SUM_W'(pix_ff.red_in);
         mem_wdata.sum_alpha = SUM_W'(pix_ff.alpha_in);
         mem_wdata.count     = CNT_W'(1);
      end else begin
         mem_wdata.sum_blue  = mem_rdata.sum_blue  + SUM_W'(pix_ff.blue_in);
         mem_wdata.sum_green = mem_rdata.sum_green + SUM_W'(pix_ff.green_in);
         mem_wdata.sum_red   = mem_rdata.sum_red   + SUM_W'(pix_ff.red_in);
         mem_wdata.sum_alpha = mem_rdata.sum_alpha + SUM_W'(pix_ff.alpha_in);
         mem_wdata.count     = mem_rdata.count + CNT_W'(1);
      end
      n_div = (mem_wdata.count == '0) ? CNT_W'(1) : mem_wdata.count;
      sc1 = DIM_W'(src_col_ff) + DIM_W'(1);
      sr1 = DIM_W'(src_row_ff) + DIM_W'(1);
      // next box edge = (box + 2) * size / dst, box being the current one
      bc2 = (DIM_W+1)'(box_col_ff) + (DIM_W+1)'(2);
      br2 = (DIM_W+1)'(box_row_ff) + (DIM_W+1)'(2);
      col_num = PROD_W'(bc2) * PROD_W'(sw);
      row_num = PROD_W'(br2) * PROD_W'(sh);
   end

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      pending_in   = pending_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      box_col_in   = box_col_ff;
      box_row_in   = box_row_ff;
      col_start_in = col_start_ff;
      row_start_in = row_start_ff;
      col_bnd_in   = col_bnd_ff;
      row_bnd_in   = row_bnd_ff;
      col_bnd0_in  = col_bnd0_ff;
      row_bnd0_in  = row_bnd0_ff;
      upd_col_in   = upd_col_ff;
      upd_row_in   = upd_row_ff;
      emit_in      = emit_ff;
      eor_in       = eor_ff;
      eoi_in       = eoi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         div_dvd[l] = '0;
         div_dvs[l] = CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_in = req_data;
               if (req_data.start_of_image || pending_ff || cfg.restart) begin
                  pending_in   = 1'b0;
                  src_col_in   = '0;
                  src_row_in   = '0;
                  box_col_in   = '0;
                  box_row_in   = '0;
                  col_start_in = '0;
                  row_start_in = '0;
                  div_start    = 1'b1;
                  div_dvd[0]   = SUM_W'(sw);
                  div_dvs[0]   = CNT_W'(dw);
                  div_dvd[1]   = SUM_W'(sh);
                  div_dvs[1]   = CNT_W'(dh);
                  state_in     = S_INIT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_INIT: begin
            if (!div_busy) begin
               col_bnd_in  = DIM_W'(div_quo[0]);
               row_bnd_in  = DIM_W'(div_quo[1]);
               col_bnd0_in = DIM_W'(div_quo[0]);
               row_bnd0_in = DIM_W'(div_quo[1]);
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            emit_in = (sc1 == col_bnd_ff) && (sr1 == row_bnd_ff);
            eor_in  = (DIM_W'(box_col_ff) + DIM_W'(1)) == dw;
            eoi_in  = eor_in && ((DIM_W'(box_row_ff) + DIM_W'(1)) == dh);
            upd_col_in = 1'b0;
            upd_row_in = 1'b0;
            div_start  = 1'b1;
            div_dvd[0] = mem_wdata.sum_blue;
            div_dvd[1] = mem_wdata.sum_green;
            div_dvd[2] = mem_wdata.sum_red;
            div_dvd[3] = mem_wdata.sum_alpha;
            for (int l = 0; l < BND_LANE; l++) begin
               div_dvs[l] = n_div;
            end
            if (sc1 >= sw) begin
               // row wrap: column side goes back to the first box
               src_col_in   = '0;
               box_col_in   = '0;
               col_start_in = '0;
               col_bnd_in   = col_bnd0_ff;
               if (sr1 >= sh) begin
                  src_row_in   = '0;
                  box_row_in   = '0;
                  row_start_in = '0;
                  row_bnd_in   = row_bnd0_ff;
               end else begin
                  src_row_in = IDX_W'(sr1);
                  if (sr1 >= row_bnd_ff) begin
                     box_row_in        = box_row_ff + IDX_W'(1);
                     row_start_in      = IDX_W'(row_bnd_ff);
                     upd_row_in        = 1'b1;
                     div_dvd[BND_LANE] = SUM_W'(row_num);
                     div_dvs[BND_LANE] = CNT_W'(dh);
                  end
               end
            end else begin
               src_col_in = IDX_W'(sc1);
               if (sc1 >= col_bnd_ff) begin
                  box_col_in        = box_col_ff + IDX_W'(1);
                  col_start_in      = IDX_W'(col_bnd_ff);
                  upd_col_in        = 1'b1;
                  div_dvd[BND_LANE] = SUM_W'(col_num);
                  div_dvs[BND_LANE] = CNT_W'(dw);
               end
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!emit_ff || out_free) begin
               if (upd_col_ff) col_bnd_in = DIM_W'(div_quo[BND_LANE]);
               if (upd_row_ff) row_bnd_in = DIM_W'(div_quo[BND_LANE]);
               if (emit_ff) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.blue_out     = div_quo[0][PIX_W-1:0];
                  rsp_data_in.green_out    = div_quo[1][PIX_W-1:0];
                  rsp_data_in.red_out      = div_quo[2][PIX_W-1:0];
                  rsp_data_in.alpha_out    = div_quo[3][PIX_W-1:0];
                  rsp_data_in.end_of_row   = eor_ff;
                  rsp_data_in.end_of_image = eoi_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // any register write restarts the counters at the next pixel; a pixel
      // taken in the cycle right after the write restarts them itself
      if (cfg.restart && !accept) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         box_col_ff   <= '0;
         box_row_ff   <= '0;
         col_start_ff <= '0;
         row_start_ff <= '0;
         col_bnd_ff   <= '0;
         row_bnd_ff   <= '0;
         col_bnd0_ff  <= '0;
         row_bnd0_ff  <= '0;
         upd_col_ff   <= 1'b0;
         upd_row_ff   <= 1'b0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         box_col_ff   <= box_col_in;
         box_row_ff   <= box_row_in;
         col_start_ff <= col_start_in;
         row_start_ff <= row_start_in;
         col_bnd_ff   <= col_bnd_in;
         row_bnd_ff   <= row_bnd_in;
         col_bnd0_ff  <= col_bnd0_in;
         row_bnd0_ff  <= row_bnd0_in;
         upd_col_ff   <= upd_col_in;
         upd_row_ff   <= upd_row_in;
         emit_ff      <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      eor_ff      <= eor_in;
      eoi_ff      <= eoi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("input ready while divider busy");

   a_col_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |->
         (col_start_ff <= src_col_ff) && (DIM_W'(src_col_ff) < col_bnd_ff))
      else $error("source column outside current box");

   a_row_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |->
         (row_start_ff <= src_row_ff) && (DIM_W'(src_row_ff) < row_bnd_ff))
      else $error("source row outside current box");

   a_box_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |->
         (DIM_W'(box_col_ff) < dw) && (DIM_W'(box_row_ff) < dh))
      else $error("box index beyond destination size");
`endif

endmodule
